### rtl/dpr_pkg.sv
// shared types, widths and constants of the disparity reprojection block
package dpr_pkg;

   // field and datapath widths
   localparam int COORD_BITS = 12;
   localparam int COL_W      = 12;
   localparam int DISP_W     = 16;
   localparam int CH_W       = 8;
   localparam int FOC_W      = 20;
   localparam int BASE_W     = 16;
   localparam int OFS_W      = 20;
   localparam int FB_W       = FOC_W + BASE_W;
   localparam int FB_SPLIT   = FB_W / 2;
   localparam int PART_W     = OFS_W + FB_W - FB_SPLIT;
   localparam int NUM_W      = OFS_W + FB_W;
   localparam int DEN_W      = FOC_W + DISP_W;
   localparam int Q_W        = 32;

   // pipeline shape
   localparam int DIV_STEPS    = Q_W;
   localparam int FRONT_STAGES = 4;
   localparam int SIDE_DEPTH   = DIV_STEPS + 1;
   localparam int PIPE_LAT     = FRONT_STAGES + 1 + DIV_STEPS + 1;

   // register port
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 20;

   localparam logic [CSR_IDX_W-1:0] CSR_FOCAL_X  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FOCAL_Y  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_CENTER_X = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_CENTER_Y = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_BASELINE = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_DISP = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_DISP = 3'd6;

   localparam logic [FOC_W-1:0]  RST_FOCAL_X  = 20'd179200;
   localparam logic [FOC_W-1:0]  RST_FOCAL_Y  = 20'd179200;
   localparam logic [FOC_W-1:0]  RST_CENTER_X = 20'd163840;
   localparam logic [FOC_W-1:0]  RST_CENTER_Y = 20'd122880;
   localparam logic [BASE_W-1:0] RST_BASELINE = 16'd5243;
   localparam logic [DISP_W-1:0] RST_MIN_DISP = 16'd128;
   localparam logic [DISP_W-1:0] RST_MAX_DISP = 16'd24576;

   // input beat
   typedef struct packed {
      logic [COL_W-1:0]  column;
      logic [COL_W-1:0]  row;
      logic [DISP_W-1:0] disparity_raw;
      logic [CH_W-1:0]   pixel_ch0;
      logic [CH_W-1:0]   pixel_ch1;
      logic [CH_W-1:0]   pixel_ch2;
   } req_type;

   // result beat
   typedef struct packed {
      logic              point_valid;
      logic signed [Q_W-1:0] point_x;
      logic signed [Q_W-1:0] point_y;
      logic [Q_W-1:0]    point_z;
      logic [CH_W-1:0]   out_ch0;
      logic [CH_W-1:0]   out_ch1;
      logic [CH_W-1:0]   out_ch2;
   } rsp_type;

   // camera registers
   typedef struct packed {
      logic [FOC_W-1:0]  focal_x;
      logic [FOC_W-1:0]  focal_y;
      logic [FOC_W-1:0]  center_x;
      logic [FOC_W-1:0]  center_y;
      logic [BASE_W-1:0] stereo_baseline;
      logic [DISP_W-1:0] min_disparity;
      logic [DISP_W-1:0] max_disparity;
   } cfg_type;

   // operands of one divider lane
   typedef struct packed {
      logic [NUM_W-1:0] num;
      logic [DEN_W-1:0] den;
   } div_in_type;

   // quotient of one divider lane
   typedef struct packed {
      logic           ovf;
      logic [Q_W-1:0] quot;
   } div_out_type;

   // per-item control and pass-through data next to the dividers
   typedef struct packed {
      logic            vld;
      logic            point_ok;
      logic            neg_x;
      logic            neg_y;
      logic [CH_W-1:0] ch0;
      logic [CH_W-1:0] ch1;
      logic [CH_W-1:0] ch2;
   } side_type;

endpackage

### rtl/dpr_csr.sv
// camera register file written through the configuration channel
module dpr_csr import dpr_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_valid,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data,
   output cfg_type               cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   // register decode, writes past the list are dropped
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_FOCAL_X:  cfg_in.focal_x         = csr_data[FOC_W-1:0];
            CSR_FOCAL_Y:  cfg_in.focal_y         = csr_data[FOC_W-1:0];
            CSR_CENTER_X: cfg_in.center_x        = csr_data[FOC_W-1:0];
            CSR_CENTER_Y: cfg_in.center_y        = csr_data[FOC_W-1:0];
            CSR_BASELINE: cfg_in.stereo_baseline = csr_data[BASE_W-1:0];
            CSR_MIN_DISP: cfg_in.min_disparity   = csr_data[DISP_W-1:0];
            CSR_MAX_DISP: cfg_in.max_disparity   = csr_data[DISP_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.focal_x         <= RST_FOCAL_X;
         cfg_ff.focal_y         <= RST_FOCAL_Y;
         cfg_ff.center_x        <= RST_CENTER_X;
         cfg_ff.center_y        <= RST_CENTER_Y;
         cfg_ff.stereo_baseline <= RST_BASELINE;
         cfg_ff.min_disparity   <= RST_MIN_DISP;
         cfg_ff.max_disparity   <= RST_MAX_DISP;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

### rtl/dpr_front.sv
// front pipeline: range check, centre offsets, products and divider operands
module dpr_front import dpr_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       accept,
   input  req_type    req_data,
   input  cfg_type    cfg,
   output div_in_type lane_z,
   output div_in_type lane_x,
   output div_in_type lane_y,
   output side_type   side
);

   // stage a: captured beat
   logic    a_vld_ff;
   req_type a_data_ff;

   // stage a logic
   logic [COORD_BITS-1:0] u_a;
   logic [COORD_BITS-1:0] v_a;
   logic [OFS_W-1:0]      su_a;
   logic [OFS_W-1:0]      sv_a;
   logic                  nx_a;
   logic                  ny_a;
   logic                  ok_a;
   logic [FB_W-1:0]       fb_a;

   // stage b
   logic              b_vld_ff;
   logic              b_ok_ff;
   logic              b_nx_ff;
   logic              b_ny_ff;
   logic [OFS_W-1:0]  b_mx_ff;
   logic [OFS_W-1:0]  b_my_ff;
   logic [FB_W-1:0]   b_fb_ff;
   logic [DISP_W-1:0] b_d_ff;
   logic [FOC_W-1:0]  b_fy_ff;
   logic [BASE_W-1:0] b_base_ff;
   logic [CH_W-1:0]   b_ch0_ff;
   logic [CH_W-1:0]   b_ch1_ff;
   logic [CH_W-1:0]   b_ch2_ff;

   // stage c
   logic              c_vld_ff;
   logic              c_ok_ff;
   logic              c_nx_ff;
   logic              c_ny_ff;
   logic [FB_W-1:0]   c_mxb_ff;
   logic [PART_W-1:0] c_pyl_ff;
   logic [PART_W-1:0] c_pyh_ff;
   logic [FB_W-1:0]   c_fb_ff;
   logic [DISP_W-1:0] c_d_ff;
   logic [DEN_W-1:0]  c_deny_ff;
   logic [CH_W-1:0]   c_ch0_ff;
   logic [CH_W-1:0]   c_ch1_ff;
   logic [CH_W-1:0]   c_ch2_ff;

   // stage d: divider operands
   div_in_type d_z_ff;
   div_in_type d_x_ff;
   div_in_type d_y_ff;
   side_type   d_side_ff;

   logic [NUM_W-1:0] num_y_c;

   // valid chain
   always_ff @(posedge clock) begin
      if (reset) begin
         a_vld_ff <= 1'b0;
         b_vld_ff <= 1'b0;
         c_vld_ff <= 1'b0;
      end else begin
         a_vld_ff <= accept;
         b_vld_ff <= a_vld_ff;
         c_vld_ff <= b_vld_ff;
      end
   end

   // input capture
   always_ff @(posedge clock) begin
      a_data_ff <= req_data;
   end

   // threshold test, pixel position to 1/256 units, signed offsets, fx*b
   assign u_a  = a_data_ff.column[COORD_BITS-1:0];
   assign v_a  = a_data_ff.row[COORD_BITS-1:0];
   assign su_a = OFS_W'({u_a, 8'h00});
   assign sv_a = OFS_W'({v_a, 8'h00});
   assign nx_a = su_a < cfg.center_x;
   assign ny_a = sv_a < cfg.center_y;
   assign ok_a = (a_data_ff.disparity_raw > cfg.min_disparity) &&
                 (a_data_ff.disparity_raw < cfg.max_disparity);
   assign fb_a = FB_W'(cfg.focal_x) * FB_W'(cfg.stereo_baseline);

   always_ff @(posedge clock) begin
      b_ok_ff   <= ok_a;
      b_nx_ff   <= nx_a;
      b_ny_ff   <= ny_a;
      b_mx_ff   <= nx_a ? cfg.center_x - su_a : su_a - cfg.center_x;
      b_my_ff   <= ny_a ? cfg.center_y - sv_a : sv_a - cfg.center_y;
      b_fb_ff   <= fb_a;
      b_d_ff    <= a_data_ff.disparity_raw;
      b_fy_ff   <= (cfg.focal_y == '0) ? FOC_W'(1) : cfg.focal_y;
      b_base_ff <= cfg.stereo_baseline;
      b_ch0_ff  <= a_data_ff.pixel_ch0;
      b_ch1_ff  <= a_data_ff.pixel_ch1;
      b_ch2_ff  <= a_data_ff.pixel_ch2;
   end

   // products; my*fb is split into two partial products over halves of fb
   always_ff @(posedge clock) begin
      c_ok_ff   <= b_ok_ff;
      c_nx_ff   <= b_nx_ff;
      c_ny_ff   <= b_ny_ff;
      c_mxb_ff  <= FB_W'(b_mx_ff) * FB_W'(b_base_ff);
      c_pyl_ff  <= PART_W'(b_my_ff) * PART_W'(b_fb_ff[FB_SPLIT-1:0]);
      c_pyh_ff  <= PART_W'(b_my_ff) * PART_W'(b_fb_ff[FB_W-1:FB_SPLIT]);
      c_fb_ff   <= b_fb_ff;
      c_d_ff    <= b_d_ff;
      c_deny_ff <= DEN_W'(b_fy_ff) * DEN_W'(b_d_ff);
      c_ch0_ff  <= b_ch0_ff;
      c_ch1_ff  <= b_ch1_ff;
      c_ch2_ff  <= b_ch2_ff;
   end

   // recombine the partial products
   assign num_y_c = NUM_W'(c_pyl_ff) + (NUM_W'(c_pyh_ff) << FB_SPLIT);

   always_ff @(posedge clock) begin
      if (reset) begin
         d_side_ff.vld <= 1'b0;
      end else begin
         d_side_ff.vld <= c_vld_ff;
      end
      d_z_ff.num         <= NUM_W'(c_fb_ff);
      d_z_ff.den         <= DEN_W'(c_d_ff);
      d_x_ff.num         <= NUM_W'(c_mxb_ff);
      d_x_ff.den         <= DEN_W'(c_d_ff);
      d_y_ff.num         <= num_y_c;
      d_y_ff.den         <= c_deny_ff;
      d_side_ff.point_ok <= c_ok_ff;
      d_side_ff.neg_x    <= c_nx_ff;
      d_side_ff.neg_y    <= c_ny_ff;
      d_side_ff.ch0      <= c_ch0_ff;
      d_side_ff.ch1      <= c_ch1_ff;
      d_side_ff.ch2      <= c_ch2_ff;
   end

   assign lane_z = d_z_ff;
   assign lane_x = d_x_ff;
   assign lane_y = d_y_ff;
   assign side   = d_side_ff;

endmodule

### rtl/dpr_divider.sv
// pipelined restoring divider, one quotient bit per stage, overflow past 32 bits flagged
module dpr_divider import dpr_pkg::*; (
   input  logic        clock,
   input  div_in_type  lane_in,
   output div_out_type lane_out
);

   // partial remainder with the numerator low bits and quotient sharing one shift word
   typedef struct packed {
      logic             ovf;
      logic [DEN_W-1:0] den;
      logic [DEN_W-1:0] rem;
      logic [Q_W-1:0]   nq;
   } lane_type;

   lane_type init_ff;
   lane_type stage_ff [DIV_STEPS];
   lane_type stage_in [DIV_STEPS];

   logic [DEN_W-1:0] hi_in;

   function automatic lane_type div_step(lane_type s);
      lane_type         r;
      logic [DEN_W:0]   t;
      logic [DEN_W:0]   diff;
      logic             ge;
      r    = s;
      t    = {s.rem, s.nq[Q_W-1]};
      diff = t - {1'b0, s.den};
      ge   = t >= {1'b0, s.den};
      r.rem = ge ? diff[DEN_W-1:0] : t[DEN_W-1:0];
      r.nq  = {s.nq[Q_W-2:0], ge};
      return r;
   endfunction

   // upper numerator bits seed the remainder; quotient too wide if they reach the divisor
   assign hi_in = DEN_W'(lane_in.num[NUM_W-1:Q_W]);

   always_ff @(posedge clock) begin
      init_ff.ovf <= hi_in >= lane_in.den;
      init_ff.den <= lane_in.den;
      init_ff.rem <= hi_in;
      init_ff.nq  <= lane_in.num[Q_W-1:0];
   end

   // quotient steps
   for (genvar i = 0; i < DIV_STEPS; i++) begin : g_step
      if (i == 0) begin : g_first
         assign stage_in[i] = div_step(init_ff);
      end else begin : g_next
         assign stage_in[i] = div_step(stage_ff[i-1]);
      end

      always_ff @(posedge clock) begin
         stage_ff[i] <= stage_in[i];
      end
   end

   assign lane_out.ovf  = stage_ff[DIV_STEPS-1].ovf;
   assign lane_out.quot = stage_ff[DIV_STEPS-1].nq;

endmodule

### rtl/dpr_back.sv
// output stage: sign, saturation, invalid point clearing and result register
module dpr_back import dpr_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  div_out_type quo_z,
   input  div_out_type quo_x,
   input  div_out_type quo_y,
   input  side_type    side,
   output logic        rsp_strobe,
   output rsp_type     rsp_data
);

   logic    rsp_strobe_ff;
   rsp_type rsp_data_ff;
   rsp_type rsp_data_in;

   // signed result from magnitude, clamped to the 32-bit range
   function automatic logic [Q_W-1:0] sat_signed(logic neg, div_out_type q);
      logic [Q_W-1:0] lim_pos;
      logic [Q_W-1:0] lim_neg;
      lim_pos = {1'b0, {(Q_W-1){1'b1}}};
      lim_neg = {1'b1, {(Q_W-1){1'b0}}};
      if (neg) begin
         return (q.ovf || (q.quot > lim_neg)) ? lim_neg : Q_W'(0) - q.quot;
      end
      return (q.ovf || q.quot[Q_W-1]) ? lim_pos : q.quot;
   endfunction

   always_comb begin
      rsp_data_in.point_valid = side.point_ok;
      rsp_data_in.point_x     = '0;
      rsp_data_in.point_y     = '0;
      rsp_data_in.point_z     = '0;
      if (side.point_ok) begin
         rsp_data_in.point_x = sat_signed(side.neg_x, quo_x);
         rsp_data_in.point_y = sat_signed(side.neg_y, quo_y);
         rsp_data_in.point_z = quo_z.ovf ? '1 : quo_z.quot;
      end
      rsp_data_in.out_ch0 = side.ch0;
      rsp_data_in.out_ch1 = side.ch1;
      rsp_data_in.out_ch2 = side.ch2;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= side.vld;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_data_ff;

endmodule

### rtl/disparity_to_point_reprojection.sv
// top level of the disparity to 3-d point reprojection pipeline
//
//   channel  ports                                  handshake
//   request  start, busy, req_data                  beat taken when start and not busy
//   result   rsp_strobe, rsp_data                   beat valid for one cycle, no back-pressure
//   config   csr_valid, csr_ready, csr_index/data   write when valid and ready
//
// one pixel is taken every cycle while busy is low; each result follows its request
// beat through the four front stages, the divider seed stage, the 32 one-bit
// quotient stages of the three dividers and the output register.
// busy is high during reset and for the first cycle after it, low otherwise.
// nothing stalls inside the pipeline: results leave in order, one per request.
module disparity_to_point_reprojection import dpr_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  req_type               req_data,
   output logic                  rsp_strobe,
   output rsp_type               rsp_data,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   logic        busy_ff;
   logic        accept;
   cfg_type     cfg;
   div_in_type  lane_z;
   div_in_type  lane_x;
   div_in_type  lane_y;
   div_out_type quo_z;
   div_out_type quo_x;
   div_out_type quo_y;
   side_type    front_side;
   side_type    side_ff [SIDE_DEPTH];

   // request acceptance
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b1;
      end else begin
         busy_ff <= 1'b0;
      end
   end

   assign busy      = busy_ff;
   assign accept    = start && !busy_ff;
   assign csr_ready = 1'b1;

   dpr_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   dpr_front u_front (
      .clock    (clock),
      .reset    (reset),
      .accept   (accept),
      .req_data (req_data),
      .cfg      (cfg),
      .lane_z   (lane_z),
      .lane_x   (lane_x),
      .lane_y   (lane_y),
      .side     (front_side)
   );

   // depth, lateral and vertical dividers
   dpr_divider u_div_z (
      .clock    (clock),
      .lane_in  (lane_z),
      .lane_out (quo_z)
   );

   dpr_divider u_div_x (
      .clock    (clock),
      .lane_in  (lane_x),
      .lane_out (quo_x)
   );

   dpr_divider u_div_y (
      .clock    (clock),
      .lane_in  (lane_y),
      .lane_out (quo_y)
   );

   // control and colour bytes delayed alongside the dividers
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < SIDE_DEPTH; i++) begin
            side_ff[i].vld <= 1'b0;
         end
      end else begin
         side_ff[0] <= front_side;
         for (int i = 1; i < SIDE_DEPTH; i++) begin
            side_ff[i] <= side_ff[i-1];
         end
      end
   end

   dpr_back u_back (
      .clock      (clock),
      .reset      (reset),
      .quo_z      (quo_z),
      .quo_x      (quo_x),
      .quo_y      (quo_y),
      .side       (side_ff[SIDE_DEPTH-1]),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

endmodule

### rtl/dpr_checker.sv
// port-level checks on the reprojection top level and their binding
module dpr_checker import dpr_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    start,
   input logic    busy,
   input logic    rsp_strobe,
   input rsp_type rsp_data
);

   // every request beat yields a result after the fixed latency
   a_req_to_rsp: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##PIPE_LAT rsp_strobe)
      else $error("request beat without result beat");

   // no result beat without a matching request beat
   a_rsp_from_req: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(start && !busy, PIPE_LAT))
      else $error("result beat without request beat");

   // rejected points carry zero coordinates
   a_invalid_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_data.point_valid) |->
         (rsp_data.point_x == 0 && rsp_data.point_y == 0 && rsp_data.point_z == 0))
      else $error("rejected point with nonzero coordinates");

   // no request taken in the cycle right after reset
   a_busy_after_reset: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> busy)
      else $error("busy low right after reset");

endmodule

bind disparity_to_point_reprojection dpr_checker u_dpr_checker (.*);

### tb/dpr_point_checker.sv
// checker for the reprojection block: mirrors the camera registers, predicts and compares points
module dpr_point_checker import dpr_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic                  busy,
   input  req_type               req_data,
   input  logic                  rsp_strobe,
   input  rsp_type               rsp_data,
   input  logic                  csr_valid,
   input  logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data,
   output int                    error_count,
   output int                    points_in_flight
);

   cfg_type camera;
   rsp_type expected_points[$];

   // quotient truncated toward zero, clamped to the signed 32-bit range
   function automatic logic [Q_W-1:0] clamp_quotient(input logic neg, input logic [63:0] mag,
                                                     input logic [63:0] den);
      logic [63:0] q;
      q = mag / den;
      if (neg) begin
         if (q > 64'h8000_0000) q = 64'h8000_0000;
         q = 64'd0 - q;
      end else if (q > 64'h7FFF_FFFF) begin
         q = 64'h7FFF_FFFF;
      end
      return q[Q_W-1:0];
   endfunction

   // point for one pixel under the given camera registers
   function automatic rsp_type reproject(input req_type pix, input cfg_type cam);
      rsp_type pt;
      logic [63:0] disp, fy, fb, su, sv, mx, my, depth;
      logic nx, ny;
      pt = '0;
      pt.out_ch0 = pix.pixel_ch0;
      pt.out_ch1 = pix.pixel_ch1;
      pt.out_ch2 = pix.pixel_ch2;
      disp = 64'(pix.disparity_raw);
      pt.point_valid = (disp > 64'(cam.min_disparity)) && (disp < 64'(cam.max_disparity));
      if (pt.point_valid) begin
         // zero vertical focal length acts as one
         fy = (cam.focal_y == '0) ? 64'd1 : 64'(cam.focal_y);
         su = 64'(pix.column[COORD_BITS-1:0]) << 8;
         sv = 64'(pix.row[COORD_BITS-1:0]) << 8;
         nx = su < 64'(cam.center_x);
         ny = sv < 64'(cam.center_y);
         mx = nx ? 64'(cam.center_x) - su : su - 64'(cam.center_x);
         my = ny ? 64'(cam.center_y) - sv : sv - 64'(cam.center_y);
         fb = 64'(cam.focal_x) * 64'(cam.stereo_baseline);
         depth = fb / disp;
         pt.point_z = (depth > 64'hFFFF_FFFF) ? '1 : depth[Q_W-1:0];
         pt.point_x = clamp_quotient(nx, mx * 64'(cam.stereo_baseline), disp);
         pt.point_y = clamp_quotient(ny, my * fb, fy * disp);
      end
      return pt;
   endfunction

   function automatic void check_field(input string field, input logic [Q_W-1:0] want,
                                       input logic [Q_W-1:0] got);
      if (want !== got) begin
         error_count++;
         $display("%0t: %s mismatch, expected %0h actual %0h", $time, field, want, got);
      end
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         camera = '{RST_FOCAL_X, RST_FOCAL_Y, RST_CENTER_X, RST_CENTER_Y,
                    RST_BASELINE, RST_MIN_DISP, RST_MAX_DISP};
         expected_points.delete();
      end else begin
         // result beat against the oldest prediction
         if (rsp_strobe) begin
            if (expected_points.size() == 0) begin
               error_count++;
               $display("%0t: unexpected point, expected none actual %p", $time, rsp_data);
            end else begin
               want = expected_points.pop_front();
               check_field("point_valid", Q_W'(want.point_valid), Q_W'(rsp_data.point_valid));
               check_field("point_x", want.point_x, rsp_data.point_x);
               check_field("point_y", want.point_y, rsp_data.point_y);
               check_field("point_z", want.point_z, rsp_data.point_z);
               check_field("out_ch0", Q_W'(want.out_ch0), Q_W'(rsp_data.out_ch0));
               check_field("out_ch1", Q_W'(want.out_ch1), Q_W'(rsp_data.out_ch1));
               check_field("out_ch2", Q_W'(want.out_ch2), Q_W'(rsp_data.out_ch2));
            end
         end
         // pixel beat, predicted with the registers in force now
         if (start && !busy)
            expected_points.insert(expected_points.size(), reproject(req_data, camera));
         // register beat, masked to the register width
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_FOCAL_X:  camera.focal_x = csr_data[FOC_W-1:0];
               CSR_FOCAL_Y:  camera.focal_y = csr_data[FOC_W-1:0];
               CSR_CENTER_X: camera.center_x = csr_data[OFS_W-1:0];
               CSR_CENTER_Y: camera.center_y = csr_data[OFS_W-1:0];
               CSR_BASELINE: camera.stereo_baseline = csr_data[BASE_W-1:0];
               CSR_MIN_DISP: camera.min_disparity = csr_data[DISP_W-1:0];
               CSR_MAX_DISP: camera.max_disparity = csr_data[DISP_W-1:0];
               default: ;
            endcase
         end
      end
      points_in_flight = expected_points.size();
   end

endmodule

### tb/tb_disparity_to_point_reprojection.sv
// testbench top for the reprojection block: clock, reset, pixel and camera stimulus, verdict
module tb_disparity_to_point_reprojection;
   import dpr_pkg::*;

   localparam int NUM_REGS     = int'(CSR_MAX_DISP) + 1;
   localparam int STALL_LIMIT  = 1000;
   localparam int DRAIN_CYCLES = 2 * PIPE_LAT;
   localparam int RAND_PHASES  = 6;
   localparam int PHASE_PIXELS = 250;

   typedef logic [CSR_DATA_W-1:0] camera_regs_type [NUM_REGS];

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  start = 1'b0;
   logic                  busy;
   req_type               req_data = '0;
   logic                  rsp_strobe;
   rsp_type               rsp_data;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_data = '0;
   int                    error_count;
   int                    points_in_flight;
   int                    stall_cycles = 0;
   int                    disp_lo = int'(RST_MIN_DISP);
   int                    disp_hi = int'(RST_MAX_DISP);

   always #1 clock = ~clock;

   disparity_to_point_reprojection u_dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   dpr_point_checker u_checker (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_data         (req_data),
      .rsp_strobe       (rsp_strobe),
      .rsp_data         (rsp_data),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data),
      .error_count      (error_count),
      .points_in_flight (points_in_flight)
   );

   // watchdog on cycles in which no beat moves on any channel
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe || (csr_valid && csr_ready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("%0t: no beat for %0d cycles", $time, STALL_LIMIT);
         $display("CHECKS FAILED");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   function automatic req_type pixel(input int col, input int row, input int disp,
                                     input int c0, input int c1, input int c2);
      req_type p;
      p.column = COL_W'(col);
      p.row = COL_W'(row);
      p.disparity_raw = DISP_W'(disp);
      p.pixel_ch0 = CH_W'(c0);
      p.pixel_ch1 = CH_W'(c1);
      p.pixel_ch2 = CH_W'(c2);
      return p;
   endfunction

   // random pixel, disparity mostly inside the valid window
   function automatic req_type random_pixel();
      req_type p;
      int unsigned pick;
      p = req_type'({$urandom, $urandom});
      pick = $urandom_range(0, 9);
      if (pick < 7 && disp_hi > disp_lo + 1) begin
         p.disparity_raw = DISP_W'($urandom_range(disp_lo + 1, disp_hi - 1));
      end else if (pick < 9) begin
         case ($urandom_range(0, 3))
            0: p.disparity_raw = DISP_W'(disp_lo);
            1: p.disparity_raw = DISP_W'(disp_hi);
            2: p.disparity_raw = DISP_W'(disp_lo + 1);
            default: p.disparity_raw = DISP_W'(disp_hi - 1);
         endcase
      end
      return p;
   endfunction

   // random camera; 16-bit registers get junk in the upper bits to exercise masking
   function automatic camera_regs_type random_camera();
      camera_regs_type r;
      int unsigned lo;
      lo = $urandom_range(0, 3000);
      r[CSR_FOCAL_X] = $urandom_range(0, 1) ? CSR_DATA_W'($urandom_range(1, 20'hFFFFF))
                                           : CSR_DATA_W'($urandom_range(100000, 260000));
      r[CSR_FOCAL_Y] = $urandom_range(0, 1) ? CSR_DATA_W'($urandom_range(1, 20'hFFFFF))
                                           : CSR_DATA_W'($urandom_range(100000, 260000));
      r[CSR_CENTER_X] = CSR_DATA_W'($urandom);
      r[CSR_CENTER_Y] = CSR_DATA_W'($urandom);
      r[CSR_BASELINE] = {4'($urandom), 16'($urandom_range(1, 16'hFFFF))};
      r[CSR_MIN_DISP] = {4'($urandom), 16'(lo)};
      r[CSR_MAX_DISP] = {4'($urandom), 16'($urandom_range(lo + 2, 16'hFFFF))};
      return r;
   endfunction

   // one pixel beat; returns at the falling edge after it was taken, start still high
   task automatic send_pixel(input req_type p);
      req_data <= p;
      start <= 1'b1;
      do @(posedge clock); while (busy);
      @(negedge clock);
   endtask

   task automatic hold_off(input int cycles);
      start <= 1'b0;
      repeat (cycles) @(negedge clock);
   endtask

   // stop sending and wait for every outstanding point
   task automatic drain_points();
      start <= 1'b0;
      while (points_in_flight != 0) @(negedge clock);
   endtask

   // write all camera registers back to back; block must be idle
   task automatic program_camera(input camera_regs_type regs);
      csr_valid <= 1'b1;
      for (int i = 0; i < NUM_REGS; i++) begin
         csr_index <= CSR_IDX_W'(i);
         csr_data <= regs[i];
         do @(posedge clock); while (!csr_ready);
         @(negedge clock);
      end
      csr_valid <= 1'b0;
      disp_lo = int'(regs[CSR_MIN_DISP][DISP_W-1:0]);
      disp_hi = int'(regs[CSR_MAX_DISP][DISP_W-1:0]);
   endtask

   initial begin
      camera_regs_type cam;
      logic quiet;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset camera: centre pixel, zero disparity, both bounds, corners
      send_pixel(pixel(640, 480, 1000, 8'h00, 8'h00, 8'h00));
      send_pixel(pixel(0, 0, 0, 8'hFF, 8'hFF, 8'hFF));
      send_pixel(pixel(4095, 4095, 128, 8'hA5, 8'h5A, 8'h0F));
      send_pixel(pixel(0, 0, 129, 8'h01, 8'h80, 8'hFE));
      send_pixel(pixel(4095, 4095, 24575, 8'hFF, 8'h00, 8'hFF));
      send_pixel(pixel(4095, 0, 24576, 8'h00, 8'hFF, 8'h00));
      send_pixel(pixel(0, 4095, 65535, 8'h7F, 8'h7F, 8'h7F));
      send_pixel(pixel(639, 481, 300, 8'h33, 8'hCC, 8'h55));

      // every register but the lower disparity bound at its maximum: negative saturation and saturated depth
      drain_points();
      cam = '{20'hFFFFF, 20'hFFFFF, 20'hFFFFF, 20'hFFFFF, 20'hFFFFF, 20'hF0001, 20'hFFFFF};
      program_camera(cam);
      send_pixel(pixel(0, 0, 2, 8'h11, 8'h22, 8'h33));
      send_pixel(pixel(4095, 4095, 65534, 8'h44, 8'h55, 8'h66));
      send_pixel(pixel(4095, 4095, 65535, 8'h77, 8'h88, 8'h99));
      send_pixel(pixel(2048, 2048, 1, 8'hAA, 8'hBB, 8'hCC));

      // zero vertical focal length, centre at origin, open lower bound
      drain_points();
      cam = '{20'hFFFFF, 20'h00000, 20'h00000, 20'h00000, 20'h0FFFF, 20'h00000, 20'h0FFFF};
      program_camera(cam);
      send_pixel(pixel(4095, 4095, 1, 8'hDD, 8'hEE, 8'hFF));
      send_pixel(pixel(0, 0, 1, 8'h01, 8'h02, 8'h03));
      send_pixel(pixel(1, 1, 65534, 8'h04, 8'h05, 8'h06));
      send_pixel(pixel(0, 0, 0, 8'h07, 8'h08, 8'h09));

      // zero horizontal focal length and zero baseline give zero coordinates
      drain_points();
      cam = '{20'h00000, 20'hFFFFF, 20'hFFFFF, 20'h00000, 20'h00000, 20'h00000, 20'h0FFFF};
      program_camera(cam);
      send_pixel(pixel(4095, 0, 500, 8'h10, 8'h20, 8'h30));
      send_pixel(pixel(0, 4095, 65534, 8'h40, 8'h50, 8'h60));

      // inverted window: nothing is valid
      drain_points();
      cam = '{20'd179200, 20'd179200, 20'd163840, 20'd122880, 20'd5243, 20'h0FFFF, 20'h00000};
      program_camera(cam);
      send_pixel(pixel(100, 100, 1000, 8'h70, 8'h80, 8'h90));
      send_pixel(pixel(4095, 4095, 32768, 8'hFF, 8'hFF, 8'hFF));

      // random cameras, random pixels with gaps; the second and the last phase run at full rate
      for (int ph = 0; ph < RAND_PHASES; ph++) begin
         drain_points();
         program_camera(random_camera());
         quiet = (ph == 1) || (ph == RAND_PHASES - 1);
         for (int n = 0; n < PHASE_PIXELS; n++) begin
            if (ph == 2 && n == PHASE_PIXELS / 2)
               drain_points();
            else if (!quiet && $urandom_range(0, 5) == 0)
               hold_off($urandom_range(1, 19));
            send_pixel(random_pixel());
         end
      end

      drain_points();
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (error_count == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule
